FILE: hw/rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// shared constants and types of the packet threat classifier
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int SET_DEPTH     = 64;
  localparam int POSITION_BITS = 16;
  localparam int SET_ABITS     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int SET_CBITS     = $clog2(SET_DEPTH + 1);

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] ETH_ARP   = 16'h0806;
  localparam logic [15:0] ARP_REPLY = 16'd2;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [5:0]  FLAG_SYN  = 6'h02;

  localparam logic [15:0] WATCHED_PORT_RST = 16'd80;
  localparam logic [63:0] PATTERN_HI_RST   = 64'd8608480253929549671;
  localparam logic [63:0] PATTERN_LO_RST   = 64'd7810700133345949035;

  typedef enum logic [1:0] {
    REG_WATCHED_PORT = 2'd0,
    REG_PATTERN_HI   = 2'd1,
    REG_PATTERN_LO   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN
  } ptc_state_t;

endpackage

FILE: hw/rtl/ptc_if.sv
// ----------------------------------------------------------------------------
// ptc_in_if / ptc_out_if
// valid/ready channels carrying frame bytes and per-frame results
// ----------------------------------------------------------------------------
interface ptc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;
  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface ptc_out_if;
  logic        valid;
  logic        ready;
  logic        arp_reply_seen;
  logic        syn_only_seen;
  logic        address_added;
  logic        set_full;
  logic        pattern_hit;
  logic [31:0] sender_address;
  modport source (output valid, arp_reply_seen, syn_only_seen, address_added,
                  set_full, pattern_hit, sender_address, input ready);
  modport sink   (input valid, arp_reply_seen, syn_only_seen, address_added,
                  set_full, pattern_hit, sender_address, output ready);
endinterface

FILE: hw/rtl/packet_threat_classifier.sv
// ----------------------------------------------------------------------------
// packet_threat_classifier
// parses ethernet frames a byte per beat and classifies each frame at its end
// ----------------------------------------------------------------------------
// throughput: one byte per cycle in a frame, stalled by scans or held results
// result: registered, valid in the cycle after the last byte; a syn-only frame
//   first scans the stored addresses (max 64) until a match or the last entry;
//   the address memory is scanned one entry per cycle, input stalls meanwhile
// reset: synchronous, rst_n low clears frame state and address set, loads config defaults
module packet_threat_classifier
  import ptc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  ptc_in_if.sink           in_bus,
  ptc_out_if.source        out_bus,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [63:0]      cfg_data
);

  localparam logic [SET_CBITS-1:0] SET_FULL_CNT = SET_CBITS'(SET_DEPTH);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [15:0]  watched_port_r;
  logic [127:0] pattern_r;

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [15:0]  ftype_r, ftype_nxt;
  logic [3:0]   ihl_r, ihl_nxt;
  logic [7:0]   proto_r, proto_nxt;
  logic [31:0]  src_r, src_nxt;
  logic [3:0]   doff_r, doff_nxt;
  logic [5:0]   flags_r, flags_nxt;
  logic [15:0]  dport_r, dport_nxt;
  logic [15:0]  opcode_r, opcode_nxt;
  logic [127:0] win_r, win_nxt;
  logic [4:0]   wcnt_r, wcnt_nxt;
  logic         term_r, term_nxt;
  logic         match_r, match_nxt;

  logic [6:0]   tcp_base;
  logic [POSITION_BITS-1:0] rel;
  logic [6:0]   pay_start;
  logic [7:0]   b;
  logic         in_fire, end_fire, syn_now;

  ptc_state_t   state_r, state_nxt;
  logic [31:0]  mem [SET_DEPTH];
  logic [31:0]  mem_q_r;
  logic         chk_r;
  logic [SET_CBITS-1:0] scan_r;
  logic [SET_CBITS-1:0] cnt_r;
  logic [31:0]  key_r;

  logic         out_valid_r;
  logic         o_arp_r, o_syn_r, o_add_r, o_full_r, o_hit_r;
  logic [31:0]  o_src_r;

  logic         found, scan_done;

  assign b        = in_bus.frame_byte;
  assign in_bus.ready = (state_r == ST_IDLE) && (!out_valid_r || out_bus.ready);
  assign in_fire  = in_bus.valid && in_bus.ready;
  assign end_fire = in_fire && in_bus.frame_end;

  always_comb begin
    pos_nxt    = pos_r;
    ftype_nxt  = ftype_r;
    ihl_nxt    = ihl_r;
    proto_nxt  = proto_r;
    src_nxt    = src_r;
    doff_nxt   = doff_r;
    flags_nxt  = flags_r;
    dport_nxt  = dport_r;
    opcode_nxt = opcode_r;
    win_nxt    = win_r;
    wcnt_nxt   = wcnt_r;
    term_nxt   = term_r;
    match_nxt  = match_r;
    rel        = '0;
    pay_start  = 7'd13;
    if (pos_r == POSITION_BITS'(12)) ftype_nxt[15:8] = b;
    if (pos_r == POSITION_BITS'(13)) ftype_nxt[7:0] = b;
    if (pos_r == POSITION_BITS'(14)) ihl_nxt = b[3:0];
    if (pos_r == POSITION_BITS'(20)) opcode_nxt[15:8] = b;
    if (pos_r == POSITION_BITS'(21)) opcode_nxt[7:0] = b;
    if (pos_r == POSITION_BITS'(23)) proto_nxt = b;
    if (pos_r >= POSITION_BITS'(26) && pos_r <= POSITION_BITS'(29)) begin
      src_nxt = {src_r[23:0], b};
    end
    tcp_base = 7'd14 + {1'b0, ihl_nxt, 2'b00};
    if (pos_r >= POSITION_BITS'(14) && pos_r >= POSITION_BITS'(tcp_base)) begin
      rel = pos_r - POSITION_BITS'(tcp_base);
      if (rel == POSITION_BITS'(2)) dport_nxt[15:8] = b;
      if (rel == POSITION_BITS'(3)) dport_nxt[7:0] = b;
      if (rel == POSITION_BITS'(12)) doff_nxt = b[7:4];
      if (rel == POSITION_BITS'(13)) flags_nxt = b[5:0];
      if ({1'b0, doff_r, 2'b00} > 7'd13) pay_start = {1'b0, doff_r, 2'b00};
      if (rel >= POSITION_BITS'(13) && rel >= POSITION_BITS'(pay_start) && !term_r) begin
        if (b == 8'd0) begin
          term_nxt = 1'b1;
        end else begin
          win_nxt = {win_r[119:0], b};
          if (wcnt_r != 5'd16) wcnt_nxt = wcnt_r + 5'd1;
          if (wcnt_nxt == 5'd16 && win_nxt == pattern_r) match_nxt = 1'b1;
        end
      end
    end
    if (pos_r != POS_MAX) pos_nxt = pos_r + 1'b1;
  end

  assign syn_now = (ftype_nxt == ETH_IPV4) && (proto_nxt == PROTO_TCP) &&
                   (flags_nxt == FLAG_SYN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watched_port_r <= WATCHED_PORT_RST;
      pattern_r      <= {PATTERN_HI_RST, PATTERN_LO_RST};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WATCHED_PORT: watched_port_r   <= cfg_data[15:0];
        REG_PATTERN_HI:   pattern_r[127:64] <= cfg_data;
        REG_PATTERN_LO:   pattern_r[63:0]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-frame parse state
  always_ff @(posedge clk) begin
    if (!rst_n || end_fire) begin
      pos_r    <= '0;
      ftype_r  <= '0;
      ihl_r    <= '0;
      proto_r  <= '0;
      src_r    <= '0;
      doff_r   <= '0;
      flags_r  <= '0;
      dport_r  <= '0;
      opcode_r <= '0;
      win_r    <= '0;
      wcnt_r   <= '0;
      term_r   <= 1'b0;
      match_r  <= 1'b0;
    end else if (in_fire) begin
      pos_r    <= pos_nxt;
      ftype_r  <= ftype_nxt;
      ihl_r    <= ihl_nxt;
      proto_r  <= proto_nxt;
      src_r    <= src_nxt;
      doff_r   <= doff_nxt;
      flags_r  <= flags_nxt;
      dport_r  <= dport_nxt;
      opcode_r <= opcode_nxt;
      win_r    <= win_nxt;
      wcnt_r   <= wcnt_nxt;
      term_r   <= term_nxt;
      match_r  <= match_nxt;
    end
  end

  // address set scan
  assign found     = (state_r == ST_SCAN) && chk_r && (mem_q_r == key_r);
  assign scan_done = (state_r == ST_SCAN) && !chk_r && (scan_r >= cnt_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (end_fire && syn_now) state_nxt = ST_SCAN;
      ST_SCAN: if (found || scan_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    mem_q_r <= mem[scan_r[SET_ABITS-1:0]];
    if (scan_done && cnt_r != SET_FULL_CNT) mem[cnt_r[SET_ABITS-1:0]] <= key_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r  <= 1'b0;
      scan_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (end_fire) begin
        scan_r <= '0;
        chk_r  <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        chk_r <= (scan_r < cnt_r) && !found;
        if (scan_r < cnt_r) scan_r <= scan_r + 1'b1;
      end
      if (scan_done && cnt_r != SET_FULL_CNT) cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (end_fire) key_r <= src_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((end_fire && !syn_now) || found || scan_done) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_fire) begin
      o_arp_r  <= (ftype_nxt == ETH_ARP) && (opcode_nxt == ARP_REPLY);
      o_syn_r  <= syn_now;
      o_hit_r  <= (ftype_nxt == ETH_IPV4) && (dport_nxt == watched_port_r) && match_nxt;
      o_src_r  <= src_nxt;
      o_add_r  <= 1'b0;
      o_full_r <= 1'b0;
    end else if (scan_done) begin
      o_add_r  <= (cnt_r != SET_FULL_CNT);
      o_full_r <= (cnt_r == SET_FULL_CNT);
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.arp_reply_seen = o_arp_r;
  assign out_bus.syn_only_seen  = o_syn_r;
  assign out_bus.address_added  = o_add_r;
  assign out_bus.set_full       = o_full_r;
  assign out_bus.pattern_hit    = o_hit_r;
  assign out_bus.sender_address = o_src_r;

endmodule

FILE: hw/rtl/ptc_checker.sv
// ----------------------------------------------------------------------------
// ptc_checker
// port-level checks of the packet threat classifier
// ----------------------------------------------------------------------------
module ptc_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_syn,
  input logic out_add,
  input logic out_full
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");

  a_add_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_add && out_full)) else $error("added and full together");

  a_add_syn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_add || out_full) |-> out_syn)
    else $error("set update without syn");

endmodule

bind packet_threat_classifier ptc_checker u_ptc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_bus.valid),
  .out_ready(out_bus.ready),
  .out_syn  (out_bus.syn_only_seen),
  .out_add  (out_bus.address_added),
  .out_full (out_bus.set_full)
);
